// ===== rtl/core/tga_truecolor_rle_decoder_unit_defines.svh =====
// Assertion macros used by the TGA decoder RTL.
`ifndef TGA_TRUECOLOR_RLE_DECODER_UNIT_DEFINES_SVH
`define TGA_TRUECOLOR_RLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TGARLE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgarle: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TGARLE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgarle: next-cycle check failed");

`endif

// ===== rtl/core/tgarle_pkg.sv =====
// Shared types and constants of the TGA true-color RLE decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  // Input word kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NO_DATA      = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE     = 3'd1;
  localparam logic [2:0] ERR_BAD_DEPTH    = 3'd2;
  localparam logic [2:0] ERR_BAD_SIZE     = 3'd3;
  localparam logic [2:0] ERR_SHORT_HEADER = 3'd4;
  localparam logic [2:0] ERR_SHORT_PIXELS = 3'd5;

  // Header byte offsets
  localparam logic [4:0] HDR_ID_LEN      = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE    = 5'd2;
  localparam logic [4:0] HDR_CMAP_LEN_LO = 5'd5;
  localparam logic [4:0] HDR_CMAP_LEN_HI = 5'd6;
  localparam logic [4:0] HDR_CMAP_DEPTH  = 5'd7;
  localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH       = 5'd16;
  localparam logic [4:0] HDR_LAST        = 5'd17;

  // Header field values
  localparam logic [7:0] TYPE_NONE = 8'd0;
  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] CMAP_USED = 8'd1;

  // Counter widths
  localparam int SKIP_W = 22;
  localparam int PIX_W  = 30;

  // One accepted input word
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic        has_alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        last_run;
    logic [2:0]  error_code;
  } result_t;

endpackage

// ===== rtl/core/tga_truecolor_rle_decoder_unit.sv =====
// Top level of the streaming TGA true-color (raw and RLE) decoder.
`timescale 1ns / 1ps

// Streaming TGA decoder for image types 2 (raw) and 10 (RLE) at 24 or 32 bits
// per pixel. Feed the file one byte per word with s_tuser low, then one word
// with s_tuser high to mark end of stream. It emits one header word, then one
// run word per pixel or per RLE repeat packet (RGB(A) with a repeat count,
// m_tlast on the run that completes the image), or an error word. The block
// takes one byte per clock cycle sustained while m_tready stays high; each
// word passes an input register, one pass of the parser logic and an output
// register before its result is offered on m_tvalid. A result that waits on
// m_tready stalls the input only once the input register also holds a word.
// There is no clearing pass after reset.
module tga_truecolor_rle_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  // image_width, image_height, has_alpha, red, green, blue, alpha,
  // repeat_count, error_code, zero pad
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last_run
);

  logic                 in_valid;
  tgarle_pkg::in_item_t in_item;
  logic                 advance;
  logic                 step;
  tgarle_pkg::result_t  res;
  logic                 out_valid;
  tgarle_pkg::result_t  out_res;

  // Move the input stage when the output stage is empty or draining
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op   <= s_tuser;
      in_item.data <= s_tdata;
    end
  end

  tgarle_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  // Output register: load a result word, drop words with no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last_run;
  assign m_tdata  = {6'd0, out_res.error_code, out_res.repeat_count, out_res.alpha,
                     out_res.blue, out_res.green, out_res.red, out_res.has_alpha,
                     out_res.image_height, out_res.image_width};

endmodule

// ===== rtl/core/tgarle_parser.sv =====
// Header parser, skip counter and pixel run decoder of the TGA decoder.
`timescale 1ns / 1ps
`include "tga_truecolor_rle_decoder_unit_defines.svh"

module tgarle_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  tgarle_pkg::in_item_t item,
  output tgarle_pkg::result_t res
);

  tgarle_pkg::phase_t phase, phase_next;

  logic [4:0]                    header_index, header_index_next;
  logic [7:0]                    img_type, img_type_next;
  logic [7:0]                    img_depth, img_depth_next;
  logic [15:0]                   img_width, img_width_next;
  logic [15:0]                   img_height, img_height_next;
  logic                          cmap_present, cmap_present_next;
  logic [15:0]                   cmap_length, cmap_length_next;
  logic [tgarle_pkg::SKIP_W-1:0] skip_remaining, skip_remaining_next;
  logic [tgarle_pkg::PIX_W-1:0]  pixels_remaining, pixels_remaining_next;
  logic [7:0]                    packet_remaining, packet_remaining_next;
  logic                          packet_is_repeat, packet_is_repeat_next;
  logic [1:0]                    pixel_byte_index, pixel_byte_index_next;
  logic [31:0]                   pixel_buffer, pixel_buffer_next;

  logic                          is_eos;
  logic                          hdr_done;
  logic                          hdr_bad;
  logic [2:0]                    hdr_code;
  logic [tgarle_pkg::PIX_W-1:0]  pix_area;
  logic [5:0]                    cmap_entry_bytes;
  logic [tgarle_pkg::SKIP_W-1:0] cmap_bytes;
  logic [tgarle_pkg::SKIP_W-1:0] skip_dec;
  logic                          is_rle;
  logic                          is_32;
  logic                          pkt_hdr;
  logic                          pix_done;
  logic                          run_repeat;
  logic [tgarle_pkg::PIX_W-1:0]  pkt_rem_ext;
  logic [tgarle_pkg::PIX_W-1:0]  run_count;
  logic [tgarle_pkg::PIX_W-1:0]  pix_left;
  logic                          pix_last;
  logic [31:0]                   buf_new;

  assign is_eos = (item.op == tgarle_pkg::OP_EOS);

  // Check the header on its last byte, in priority order
  assign hdr_done = (phase == tgarle_pkg::PH_HEADER) && (header_index == tgarle_pkg::HDR_LAST);

  always_comb begin
    hdr_bad  = 1'b1;
    hdr_code = tgarle_pkg::ERR_NO_DATA;
    if (img_type == tgarle_pkg::TYPE_NONE) begin
      hdr_code = tgarle_pkg::ERR_NO_DATA;
    end else if (img_type != tgarle_pkg::TYPE_RAW && img_type != tgarle_pkg::TYPE_RLE) begin
      hdr_code = tgarle_pkg::ERR_BAD_TYPE;
    end else if (img_depth != tgarle_pkg::DEPTH_24 && img_depth != tgarle_pkg::DEPTH_32) begin
      hdr_code = tgarle_pkg::ERR_BAD_DEPTH;
    end else if (img_width == 16'd0 || img_width[15] || img_height == 16'd0 ||
                 img_height[15]) begin
      hdr_code = tgarle_pkg::ERR_BAD_SIZE;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  // Pixel count of the image
  assign pix_area = {15'd0, img_width[14:0]} * {15'd0, img_height[14:0]};

  // Color map size in bytes: length times bytes per entry
  assign cmap_entry_bytes = 6'(({1'b0, item.data} + 9'd7) >> 3);
  assign cmap_bytes       = {6'd0, cmap_length} * {16'd0, cmap_entry_bytes};
  assign skip_dec         = (skip_remaining != '0) ? skip_remaining - 1'b1 : skip_remaining;

  // Pixel assembly and run length
  assign is_rle      = (img_type == tgarle_pkg::TYPE_RLE);
  assign is_32       = (img_depth == tgarle_pkg::DEPTH_32);
  assign pkt_hdr     = is_rle && (packet_remaining == 8'd0);
  assign pix_done    = !pkt_hdr && (pixel_byte_index == (is_32 ? 2'd3 : 2'd2));
  assign run_repeat  = is_rle && packet_is_repeat;
  assign pkt_rem_ext = {{(tgarle_pkg::PIX_W-8){1'b0}}, packet_remaining};
  assign run_count   = !run_repeat ? tgarle_pkg::PIX_W'(1) :
                       (pkt_rem_ext > pixels_remaining) ? pixels_remaining : pkt_rem_ext;
  assign pix_left    = pixels_remaining - run_count;
  assign pix_last    = (pix_left == '0);

  always_comb begin
    buf_new = pixel_buffer;
    buf_new[{pixel_byte_index, 3'b000} +: 8] = item.data;
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (is_eos) begin
      phase_next = tgarle_pkg::PH_HEADER;
    end else begin
      unique case (phase)
        tgarle_pkg::PH_HEADER: begin
          if (hdr_done) begin
            if (hdr_bad) begin
              phase_next = tgarle_pkg::PH_DONE;
            end else if (skip_remaining != '0) begin
              phase_next = tgarle_pkg::PH_SKIP;
            end else begin
              phase_next = tgarle_pkg::PH_DATA;
            end
          end
        end
        tgarle_pkg::PH_SKIP: begin
          if (skip_dec == '0) begin
            phase_next = tgarle_pkg::PH_DATA;
          end
        end
        tgarle_pkg::PH_DATA: begin
          if (pix_done && pix_last) begin
            phase_next = tgarle_pkg::PH_DONE;
          end
        end
        tgarle_pkg::PH_DONE: begin
          phase_next = tgarle_pkg::PH_DONE;
        end
        default: begin
          phase_next = tgarle_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // Datapath updates and result word
  always_comb begin
    header_index_next     = header_index;
    img_type_next         = img_type;
    img_depth_next        = img_depth;
    img_width_next        = img_width;
    img_height_next       = img_height;
    cmap_present_next     = cmap_present;
    cmap_length_next      = cmap_length;
    skip_remaining_next   = skip_remaining;
    pixels_remaining_next = pixels_remaining;
    packet_remaining_next = packet_remaining;
    packet_is_repeat_next = packet_is_repeat;
    pixel_byte_index_next = pixel_byte_index;
    pixel_buffer_next     = pixel_buffer;
    res                   = '0;

    if (is_eos) begin
      // Report truncation, then rearm for the next file
      if (phase == tgarle_pkg::PH_HEADER) begin
        res.valid      = 1'b1;
        res.kind       = tgarle_pkg::KIND_ERROR;
        res.error_code = tgarle_pkg::ERR_SHORT_HEADER;
      end else if (phase == tgarle_pkg::PH_SKIP || phase == tgarle_pkg::PH_DATA) begin
        res.valid      = 1'b1;
        res.kind       = tgarle_pkg::KIND_ERROR;
        res.error_code = tgarle_pkg::ERR_SHORT_PIXELS;
      end
      header_index_next     = '0;
      img_type_next         = '0;
      img_depth_next        = '0;
      img_width_next        = '0;
      img_height_next       = '0;
      cmap_present_next     = 1'b0;
      cmap_length_next      = '0;
      skip_remaining_next   = '0;
      pixels_remaining_next = '0;
      packet_remaining_next = '0;
      packet_is_repeat_next = 1'b0;
      pixel_byte_index_next = '0;
      pixel_buffer_next     = '0;
    end else begin
      case (phase)
        tgarle_pkg::PH_HEADER: begin
          // Capture the header fields by byte offset
          unique case (header_index)
            tgarle_pkg::HDR_ID_LEN:      skip_remaining_next = {14'd0, item.data};
            tgarle_pkg::HDR_CMAP_TYPE:   cmap_present_next = (item.data == tgarle_pkg::CMAP_USED);
            tgarle_pkg::HDR_IMG_TYPE:    img_type_next = item.data;
            tgarle_pkg::HDR_CMAP_LEN_LO: cmap_length_next[7:0] = item.data;
            tgarle_pkg::HDR_CMAP_LEN_HI: cmap_length_next[15:8] = item.data;
            tgarle_pkg::HDR_CMAP_DEPTH: begin
              if (cmap_present) begin
                skip_remaining_next = skip_remaining + cmap_bytes;
              end
            end
            tgarle_pkg::HDR_WIDTH_LO:    img_width_next[7:0] = item.data;
            tgarle_pkg::HDR_WIDTH_HI:    img_width_next[15:8] = item.data;
            tgarle_pkg::HDR_HEIGHT_LO:   img_height_next[7:0] = item.data;
            tgarle_pkg::HDR_HEIGHT_HI:   img_height_next[15:8] = item.data;
            tgarle_pkg::HDR_DEPTH:       img_depth_next = item.data;
            default: ;
          endcase
          header_index_next = header_index + 1'b1;
          if (hdr_done) begin
            res.valid = 1'b1;
            if (hdr_bad) begin
              res.kind       = tgarle_pkg::KIND_ERROR;
              res.error_code = hdr_code;
            end else begin
              res.kind              = tgarle_pkg::KIND_HEADER;
              res.image_width       = img_width[14:0];
              res.image_height      = img_height[14:0];
              res.has_alpha         = is_32;
              pixels_remaining_next = pix_area;
              packet_remaining_next = '0;
              pixel_byte_index_next = '0;
            end
          end
        end
        tgarle_pkg::PH_SKIP: begin
          skip_remaining_next = skip_dec;
        end
        tgarle_pkg::PH_DATA: begin
          if (pkt_hdr) begin
            // Open a new RLE packet
            packet_is_repeat_next = item.data[7];
            packet_remaining_next = {1'b0, item.data[6:0]} + 8'd1;
            pixel_byte_index_next = '0;
          end else begin
            pixel_buffer_next = buf_new;
            if (!pix_done) begin
              pixel_byte_index_next = pixel_byte_index + 1'b1;
            end else begin
              // Pixel complete: emit one run, BGR(A) to RGB(A)
              pixel_byte_index_next = '0;
              if (run_repeat) begin
                packet_remaining_next = '0;
              end else if (packet_remaining != 8'd0) begin
                packet_remaining_next = packet_remaining - 1'b1;
              end
              pixels_remaining_next = pix_left;
              res.valid        = 1'b1;
              res.kind         = tgarle_pkg::KIND_RUN;
              res.has_alpha    = is_32;
              res.red          = buf_new[23:16];
              res.green        = buf_new[15:8];
              res.blue         = buf_new[7:0];
              res.alpha        = is_32 ? buf_new[31:24] : 8'd0;
              res.repeat_count = run_count[7:0];
              res.last_run     = pix_last;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold state between words, advance on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tgarle_pkg::PH_HEADER;
      header_index     <= '0;
      img_type         <= '0;
      img_depth        <= '0;
      img_width        <= '0;
      img_height       <= '0;
      cmap_present     <= 1'b0;
      cmap_length      <= '0;
      skip_remaining   <= '0;
      pixels_remaining <= '0;
      packet_remaining <= '0;
      packet_is_repeat <= 1'b0;
      pixel_byte_index <= '0;
      pixel_buffer     <= '0;
    end else if (step) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      img_type         <= img_type_next;
      img_depth        <= img_depth_next;
      img_width        <= img_width_next;
      img_height       <= img_height_next;
      cmap_present     <= cmap_present_next;
      cmap_length      <= cmap_length_next;
      skip_remaining   <= skip_remaining_next;
      pixels_remaining <= pixels_remaining_next;
      packet_remaining <= packet_remaining_next;
      packet_is_repeat <= packet_is_repeat_next;
      pixel_byte_index <= pixel_byte_index_next;
      pixel_buffer     <= pixel_buffer_next;
    end
  end

  // End of stream always rearms the header parser
  `TGARLE_ASSERT_NXT(a_eos_rearm, clk, rst, step && is_eos,
    phase == tgarle_pkg::PH_HEADER && header_index == '0)
  // Skip phase is only entered with bytes left to skip
  `TGARLE_ASSERT_IMP(a_skip_nonzero, clk, rst, phase == tgarle_pkg::PH_SKIP,
    skip_remaining != '0)
  // Pixel data phase always has pixels left
  `TGARLE_ASSERT_IMP(a_pixels_nonzero, clk, rst, phase == tgarle_pkg::PH_DATA,
    pixels_remaining != '0)
  // The completing run closes the image
  `TGARLE_ASSERT_NXT(a_last_closes, clk, rst, step && res.valid && res.last_run,
    phase == tgarle_pkg::PH_DONE)

endmodule
